// File: src/sfpd_pkg.sv
// Shared types, widths and helpers for the swing-foot PD force clamp.
// No dependencies; used by sfpd_clamp and swing_foot_pd_force_clamp.
`timescale 1ns / 1ps

package sfpd_pkg;

  localparam int unsigned DataW = 24;   // Q12.12 signal width
  localparam int unsigned ErrW  = 25;   // target minus actual
  localparam int unsigned GainW = 16;   // Q8.8 gain
  localparam int unsigned LimW  = 23;   // norm limit
  localparam int unsigned RotW  = 16;   // Q2.14 rotation element
  localparam int unsigned PartW = 40;   // stored P / D part
  localparam int unsigned AccW  = 41;   // serial product accumulator
  localparam int unsigned SumW  = 42;   // P + D + gravity
  localparam int unsigned SsW   = 50;   // sum of squares of normalized mags
  localparam int unsigned RootW = 25;   // floor sqrt of SsW bits

  localparam logic [LimW-1:0] GravityComp = 23'd40960;

  typedef logic [2:0][PartW-1:0] vec_t;

  typedef enum logic [2:0] {
    RegPosGainX    = 3'd0,
    RegPosGainY    = 3'd1,
    RegPosGainZ    = 3'd2,
    RegVelGainX    = 3'd3,
    RegVelGainY    = 3'd4,
    RegVelGainZ    = 3'd5,
    RegPosForceLim = 3'd6,
    RegVelForceLim = 3'd7
  } reg_idx_e;

  typedef enum logic [1:0] {
    AxisX    = 2'd0,
    AxisY    = 2'd1,
    AxisZ    = 2'd2,
    AxisNone = 2'd3
  } axis_e;

  typedef enum logic [2:0] {
    StIdle,
    StMul,
    StStore,
    StStart,
    StWait,
    StOut
  } top_state_e;

  typedef enum logic [2:0] {
    ClIdle,
    ClOver,
    ClNorm,
    ClSq,
    ClTest,
    ClSqrt,
    ClProd,
    ClDiv
  } clamp_state_e;

  function automatic logic signed [DataW-1:0] sat_sum(input logic signed [SumW-1:0] x);
    logic signed [SumW-1:0] hi;
    logic signed [SumW-1:0] lo;
    hi = SumW'(signed'(24'sh7FFFFF));
    lo = SumW'(signed'(24'sh800000));
    if (x > hi) begin
      return 24'sh7FFFFF;
    end else if (x < lo) begin
      return 24'sh800000;
    end
    return x[DataW-1:0];
  endfunction

endpackage

// File: src/sfpd_clamp.sv
// Norm clamp for one 3-vector: normalize, square-sum, bit-serial sqrt and
// bit-serial division per component. Depends on sfpd_pkg.
`timescale 1ns / 1ps

module sfpd_clamp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  sfpd_pkg::vec_t              parts_i,
  input  logic [sfpd_pkg::LimW-1:0]   limit_i,
  output logic                        busy_o,
  output sfpd_pkg::vec_t              res_o
);

  localparam int unsigned PW = sfpd_pkg::PartW;
  localparam int unsigned LW = sfpd_pkg::LimW;
  localparam int unsigned SW = sfpd_pkg::SsW;
  localparam int unsigned RW = sfpd_pkg::RootW;

  sfpd_pkg::clamp_state_e state_q, state_d;

  logic [2:0]          neg_q;
  logic [2:0][PW-1:0]  m_q;
  logic                over_q;
  logic [SW-1:0]       ss_q;
  logic [2*LW-1:0]     lsq_q;
  logic [SW-1:0]       rad_q;
  logic [RW+1:0]       rem_q;
  logic [RW-1:0]       root_q;
  logic [4:0]          cnt_q;
  logic [1:0]          sel_q;
  logic [RW-1:0]       drem_q;
  logic [LW-1:0]       dvd_q;
  logic [LW-1:0]       quo_q;
  sfpd_pkg::vec_t      res_q;

  logic                wide;
  logic [23:0]         sq_op;
  logic [47:0]         sq;
  logic [RW+3:0]       remn;
  logic [RW+3:0]       trial;
  logic [RW+3:0]       rem_sub;
  logic                sqrt_ge;
  logic [23:0]         msel;
  logic [46:0]         prod;
  logic [RW:0]         dt;
  logic [RW:0]         dsub;
  logic                div_ge;
  logic [LW-1:0]       quo_n;
  logic [PW-1:0]       qext;

  assign wide = (m_q[0][PW-1:24] != '0) || (m_q[1][PW-1:24] != '0) ||
                (m_q[2][PW-1:24] != '0);

  always_comb begin
    case (cnt_q[1:0])
      2'd0:    sq_op = m_q[0][23:0];
      2'd1:    sq_op = m_q[1][23:0];
      2'd2:    sq_op = m_q[2][23:0];
      default: sq_op = {1'b0, limit_i};
    endcase
  end
  assign sq = sq_op * sq_op;

  // restoring square root, two radicand bits per cycle
  assign remn    = {rem_q, rad_q[SW-1:SW-2]};
  assign trial   = {2'b00, root_q, 2'b01};
  assign sqrt_ge = remn >= trial;
  assign rem_sub = remn - trial;

  always_comb begin
    case (sel_q)
      2'd0:    msel = m_q[0][23:0];
      2'd1:    msel = m_q[1][23:0];
      default: msel = m_q[2][23:0];
    endcase
  end
  assign prod = msel * limit_i;

  // m <= n, so the quotient fits in LW bits and the remainder stays below n
  assign dt     = {drem_q, dvd_q[LW-1]};
  assign div_ge = dt >= {1'b0, root_q};
  assign dsub   = dt - {1'b0, root_q};
  assign quo_n  = {quo_q[LW-2:0], div_ge};
  assign qext   = {{(PW-LW){1'b0}}, quo_n};

  always_comb begin
    state_d = state_q;
    case (state_q)
      sfpd_pkg::ClIdle: if (start_i) state_d = sfpd_pkg::ClOver;
      sfpd_pkg::ClOver: state_d = sfpd_pkg::ClNorm;
      sfpd_pkg::ClNorm: if (!wide) state_d = sfpd_pkg::ClSq;
      sfpd_pkg::ClSq:   if (cnt_q[1:0] == 2'd3) state_d = sfpd_pkg::ClTest;
      sfpd_pkg::ClTest: begin
        if (!over_q && (ss_q <= {{(SW-2*LW){1'b0}}, lsq_q})) state_d = sfpd_pkg::ClIdle;
        else state_d = sfpd_pkg::ClSqrt;
      end
      sfpd_pkg::ClSqrt: if (cnt_q == 5'(RW-1)) state_d = sfpd_pkg::ClProd;
      sfpd_pkg::ClProd: state_d = sfpd_pkg::ClDiv;
      sfpd_pkg::ClDiv: begin
        if (cnt_q == 5'(LW-1)) begin
          if (sel_q == 2'd2) state_d = sfpd_pkg::ClIdle;
          else state_d = sfpd_pkg::ClProd;
        end
      end
      default: state_d = sfpd_pkg::ClIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sfpd_pkg::ClIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      sfpd_pkg::ClIdle: begin
        if (start_i) begin
          res_q <= parts_i;
          for (int j = 0; j < 3; j++) begin
            neg_q[j] <= parts_i[j][PW-1];
            m_q[j]   <= parts_i[j][PW-1] ? (~parts_i[j] + 1'b1) : parts_i[j];
          end
        end
      end
      sfpd_pkg::ClOver: begin
        over_q <= (m_q[0] > {{(PW-LW){1'b0}}, limit_i}) ||
                  (m_q[1] > {{(PW-LW){1'b0}}, limit_i}) ||
                  (m_q[2] > {{(PW-LW){1'b0}}, limit_i});
        cnt_q  <= '0;
        ss_q   <= '0;
      end
      sfpd_pkg::ClNorm: begin
        if (wide) begin
          for (int j = 0; j < 3; j++) m_q[j] <= m_q[j] >> 1;
        end
      end
      sfpd_pkg::ClSq: begin
        if (cnt_q[1:0] == 2'd3) lsq_q <= sq[2*LW-1:0];
        else ss_q <= ss_q + {{(SW-48){1'b0}}, sq};
        cnt_q <= cnt_q + 5'd1;
      end
      sfpd_pkg::ClTest: begin
        rad_q  <= ss_q;
        rem_q  <= '0;
        root_q <= '0;
        cnt_q  <= '0;
        sel_q  <= '0;
      end
      sfpd_pkg::ClSqrt: begin
        rem_q  <= sqrt_ge ? rem_sub[RW+1:0] : remn[RW+1:0];
        root_q <= {root_q[RW-2:0], sqrt_ge};
        rad_q  <= rad_q << 2;
        cnt_q  <= cnt_q + 5'd1;
      end
      sfpd_pkg::ClProd: begin
        drem_q <= {1'b0, prod[46:LW]};
        dvd_q  <= prod[LW-1:0];
        quo_q  <= '0;
        cnt_q  <= '0;
      end
      sfpd_pkg::ClDiv: begin
        drem_q <= div_ge ? dsub[RW-1:0] : dt[RW-1:0];
        dvd_q  <= dvd_q << 1;
        quo_q  <= quo_n;
        cnt_q  <= cnt_q + 5'd1;
        if (cnt_q == 5'(LW-1)) begin
          res_q[sel_q] <= neg_q[sel_q] ? (~qext + 1'b1) : qext;
          sel_q <= sel_q + 2'd1;
        end
      end
      default: ;
    endcase
  end

  assign busy_o = (state_q != sfpd_pkg::ClIdle);
  assign res_o  = res_q;

endmodule

// File: src/swing_foot_pd_force_clamp.sv
// Top level: config registers, bit-serial gain multiply, part storage,
// two sfpd_clamp instances and output register. Depends on sfpd_pkg, sfpd_clamp.
`timescale 1ns / 1ps
// Usage:
//  Requests arrive on s_axis_*: tuser carries the axis (0 x, 1 y, 2 z, 3 is
//  dropped), tdata carries target/actual position and velocity and the
//  rotation row element. Each axis request stores its P, D and gravity parts;
//  a z request then clamps the P and D vectors to their norm limits and
//  sends one result {force_z, force_y, force_x} on m_axis_*.
//  Sequence: an x or y request runs a bit-serial gain multiply over the
//  gain width, then a store, and returns to idle. A z request adds start,
//  wait and output states; the two clamps run in parallel through
//  normalize and squares, and only a vector that needs clamping goes on
//  to the bit-serial sqrt and the bit-serial division of each component.
//  One request is in work at a time; s_axis_tready is high only while idle.
//  The result waits in the output register; a stalled receiver holds the
//  block before the result is written, while earlier results stay intact.
//  Reset clears all gains to 1.0, limits and stored parts to zero.
//  Config: APB writes at byte address 4*index; pready is always high.

module swing_foot_pd_force_clamp #(
  parameter logic [sfpd_pkg::LimW-1:0] GravityComp = sfpd_pkg::GravityComp
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // [23:0] target_pos, [47:24] actual_pos, [71:48] target_vel,
  // [95:72] actual_vel, [111:96] rot_row_elem
  input  logic [111:0]  s_axis_tdata,
  // [1:0] axis
  input  logic [1:0]    s_axis_tuser,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // [23:0] force_x, [47:24] force_y, [71:48] force_z
  output logic [71:0]   m_axis_tdata
);

  localparam int unsigned DW = sfpd_pkg::DataW;
  localparam int unsigned EW = sfpd_pkg::ErrW;
  localparam int unsigned GW = sfpd_pkg::GainW;
  localparam int unsigned LW = sfpd_pkg::LimW;
  localparam int unsigned PW = sfpd_pkg::PartW;
  localparam int unsigned AW = sfpd_pkg::AccW;
  localparam int unsigned XW = sfpd_pkg::SumW;
  localparam int unsigned RTW = sfpd_pkg::RotW;
  localparam int unsigned GPW = RTW + LW + 1;

  // config registers
  logic [GW-1:0] pg_x_q, pg_y_q, pg_z_q, vg_x_q, vg_y_q, vg_z_q;
  logic [LW-1:0] plim_q, vlim_q;
  logic          cfg_we;
  sfpd_pkg::reg_idx_e cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = sfpd_pkg::reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pg_x_q <= 16'd256;
      pg_y_q <= 16'd256;
      pg_z_q <= 16'd256;
      vg_x_q <= 16'd256;
      vg_y_q <= 16'd256;
      vg_z_q <= 16'd256;
      plim_q <= '0;
      vlim_q <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        sfpd_pkg::RegPosGainX:    pg_x_q <= pwdata[GW-1:0];
        sfpd_pkg::RegPosGainY:    pg_y_q <= pwdata[GW-1:0];
        sfpd_pkg::RegPosGainZ:    pg_z_q <= pwdata[GW-1:0];
        sfpd_pkg::RegVelGainX:    vg_x_q <= pwdata[GW-1:0];
        sfpd_pkg::RegVelGainY:    vg_y_q <= pwdata[GW-1:0];
        sfpd_pkg::RegVelGainZ:    vg_z_q <= pwdata[GW-1:0];
        sfpd_pkg::RegPosForceLim: plim_q <= pwdata[LW-1:0];
        sfpd_pkg::RegVelForceLim: vlim_q <= pwdata[LW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      sfpd_pkg::RegPosGainX:    prdata = {16'd0, pg_x_q};
      sfpd_pkg::RegPosGainY:    prdata = {16'd0, pg_y_q};
      sfpd_pkg::RegPosGainZ:    prdata = {16'd0, pg_z_q};
      sfpd_pkg::RegVelGainX:    prdata = {16'd0, vg_x_q};
      sfpd_pkg::RegVelGainY:    prdata = {16'd0, vg_y_q};
      sfpd_pkg::RegVelGainZ:    prdata = {16'd0, vg_z_q};
      sfpd_pkg::RegPosForceLim: prdata = {9'd0, plim_q};
      sfpd_pkg::RegVelForceLim: prdata = {9'd0, vlim_q};
      default:                  prdata = '0;
    endcase
  end

  // request path
  sfpd_pkg::top_state_e state_q, state_d;
  sfpd_pkg::axis_e      in_axis, axis_q;
  logic                 in_acc;
  logic [3:0]           cnt_q;
  logic [AW-1:0]        pmc_q, vmc_q, pacc_q, vacc_q;
  logic [GW-1:0]        psh_q, vsh_q;
  logic [GPW-1:0]       gprod_q;
  logic [GW-1:0]        in_pg, in_vg;
  logic [EW-1:0]        pe, ve;
  logic signed [GPW-1:0] gprod;
  logic signed [AW-1:0] pround, vround;
  logic signed [GPW-1:0] ground;
  logic [DW-1:0]        gsat;
  sfpd_pkg::vec_t       pparts_q, vparts_q, pres, vres;
  logic [2:0][DW-1:0]   grav_q;
  logic                 clamp_start, pbusy, vbusy;
  logic                 mvalid_q;
  logic [71:0]          mdata_q;
  logic [2:0][DW-1:0]   force_v;

  assign in_axis = sfpd_pkg::axis_e'(s_axis_tuser);
  assign in_acc  = s_axis_tvalid && s_axis_tready;

  always_comb begin
    case (in_axis)
      sfpd_pkg::AxisX: begin in_pg = pg_x_q; in_vg = vg_x_q; end
      sfpd_pkg::AxisY: begin in_pg = pg_y_q; in_vg = vg_y_q; end
      default:         begin in_pg = pg_z_q; in_vg = vg_z_q; end
    endcase
  end

  assign pe = {s_axis_tdata[23], s_axis_tdata[23:0]} - {s_axis_tdata[47], s_axis_tdata[47:24]};
  assign ve = {s_axis_tdata[71], s_axis_tdata[71:48]} - {s_axis_tdata[95], s_axis_tdata[95:72]};
  // constant multiplier, reduces to a few adders
  assign gprod = $signed({{(GPW-RTW){s_axis_tdata[111]}}, s_axis_tdata[111:96]}) *
                 $signed({{(GPW-LW){1'b0}}, GravityComp});

  // round half up to Q12.12
  assign pround = ($signed(pacc_q) + AW'(128)) >>> 8;
  assign vround = ($signed(vacc_q) + AW'(128)) >>> 8;
  assign ground = ($signed(gprod_q) + GPW'(8192)) >>> 14;
  assign gsat   = sfpd_pkg::sat_sum(XW'(ground));

  always_comb begin
    state_d = state_q;
    case (state_q)
      sfpd_pkg::StIdle:  if (in_acc && in_axis != sfpd_pkg::AxisNone) state_d = sfpd_pkg::StMul;
      sfpd_pkg::StMul:   if (cnt_q == 4'(GW-1)) state_d = sfpd_pkg::StStore;
      sfpd_pkg::StStore: begin
        if (axis_q == sfpd_pkg::AxisZ) state_d = sfpd_pkg::StStart;
        else state_d = sfpd_pkg::StIdle;
      end
      sfpd_pkg::StStart: state_d = sfpd_pkg::StWait;
      sfpd_pkg::StWait:  if (!pbusy && !vbusy) state_d = sfpd_pkg::StOut;
      sfpd_pkg::StOut:   if (!mvalid_q || m_axis_tready) state_d = sfpd_pkg::StIdle;
      default:           state_d = sfpd_pkg::StIdle;
    endcase
  end

  always_comb begin
    s_axis_tready = (state_q == sfpd_pkg::StIdle);
    clamp_start   = (state_q == sfpd_pkg::StStart);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= sfpd_pkg::StIdle;
      pparts_q <= '0;
      vparts_q <= '0;
      grav_q   <= '0;
      mvalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == sfpd_pkg::StStore) begin
        pparts_q[axis_q] <= pround[PW-1:0];
        vparts_q[axis_q] <= vround[PW-1:0];
        grav_q[axis_q]   <= gsat;
      end
      if (state_q == sfpd_pkg::StOut && (!mvalid_q || m_axis_tready)) begin
        mvalid_q <= 1'b1;
      end else if (m_axis_tready) begin
        mvalid_q <= 1'b0;
      end
    end
  end

  // shift-add multiply, one gain bit per cycle
  always_ff @(posedge clk_i) begin
    if (state_q == sfpd_pkg::StIdle && in_acc) begin
      axis_q  <= in_axis;
      pmc_q   <= {{(AW-EW){pe[EW-1]}}, pe};
      vmc_q   <= {{(AW-EW){ve[EW-1]}}, ve};
      psh_q   <= in_pg;
      vsh_q   <= in_vg;
      pacc_q  <= '0;
      vacc_q  <= '0;
      cnt_q   <= '0;
      gprod_q <= gprod;
    end else if (state_q == sfpd_pkg::StMul) begin
      if (psh_q[0]) pacc_q <= pacc_q + pmc_q;
      if (vsh_q[0]) vacc_q <= vacc_q + vmc_q;
      pmc_q <= pmc_q << 1;
      vmc_q <= vmc_q << 1;
      psh_q <= psh_q >> 1;
      vsh_q <= vsh_q >> 1;
      cnt_q <= cnt_q + 4'd1;
    end
    if (state_q == sfpd_pkg::StOut && (!mvalid_q || m_axis_tready)) begin
      mdata_q <= {force_v[2], force_v[1], force_v[0]};
    end
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      force_v[j] = sfpd_pkg::sat_sum($signed({{(XW-PW){pres[j][PW-1]}}, pres[j]}) +
                                     $signed({{(XW-PW){vres[j][PW-1]}}, vres[j]}) +
                                     $signed({{(XW-DW){grav_q[j][DW-1]}}, grav_q[j]}));
    end
  end

  sfpd_clamp u_pclamp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (clamp_start),
    .parts_i (pparts_q),
    .limit_i (plim_q),
    .busy_o  (pbusy),
    .res_o   (pres)
  );

  sfpd_clamp u_vclamp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (clamp_start),
    .parts_i (vparts_q),
    .limit_i (vlim_q),
    .busy_o  (vbusy),
    .res_o   (vres)
  );

  assign m_axis_tvalid = mvalid_q;
  assign m_axis_tdata  = mdata_q;

endmodule
